// ----- hw/rtl/kmp_pkg.sv -----
package kmp_pkg;

   // sizing
   localparam int CLUSTERS    = 5;
   localparam int PASS_POINTS = 65536;
   localparam int COORD_BITS  = 16;

   localparam int CL_BITS   = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam int CNT_BITS  = $clog2(PASS_POINTS + 1);
   localparam int SUM_BITS  = COORD_BITS + CNT_BITS;
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int DIST_BITS = SQ_BITS + 1;

   // fixed field widths
   localparam int SLOT_BITS = 4;
   localparam int IDX_BITS  = 4;

   // stream packing
   localparam int REQ_DATA_BITS = ((SLOT_BITS + 2 * COORD_BITS) + 7) / 8 * 8;
   localparam int RSP_DATA_BITS = ((IDX_BITS + 2 * COORD_BITS + 1) + 7) / 8 * 8;

   // opcodes on req_tuser
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   // result kinds on rsp_tuser
   localparam logic KIND_ASSIGN   = 1'b0;
   localparam logic KIND_CENTROID = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic [CNT_BITS-1:0]          count_type;

endpackage

// ----- hw/rtl/kmeans_2d_pass_unit.sv -----
// Channel  Dir  Ports                    Contents
// req      in   req_tvalid/tready        one point or centroid load per beat
//               req_tuser                opcode (0 load, 1 point)
//               req_tdata                slot[3:0], x[19:4], y[35:20]
//               req_tlast                last point of the pass
// rsp      out  rsp_tvalid/tready        one assignment or centroid per beat
//               rsp_tuser                kind (0 assignment, 1 centroid)
//               rsp_tdata                index[3:0], x[19:4], y[35:20], ovf[36]
//               rsp_tlast                last beat caused by the input beat
//
// For a point beat the one squarer handles dx^2 then dy^2 for each centroid in turn.
// A pass-end point then computes every cluster's mean, x then y per cluster; the serial
// divider yields one quotient bit per cycle, and an empty cluster skips the divider and
// gets the origin.
// Reset is synchronous; it clears centroids, sums, counts and the rsp valid flag.
// req_tready is high only in idle; a held rsp beat stalls the sequencer
// right before the next result is loaded.
module kmeans_2d_pass_unit import kmp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // centroid_slot, coord_x, coord_y
   input  logic                     req_tuser,   // opcode
   input  logic                     req_tlast,   // last_of_pass
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // cluster_index, out_x, out_y, overflow
   output logic                     rsp_tuser,   // result_kind
   output logic                     rsp_tlast    // last
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SQX  = 4'd1;
   localparam logic [3:0] ST_SQY  = 4'd2;
   localparam logic [3:0] ST_CMP  = 4'd3;
   localparam logic [3:0] ST_ACC  = 4'd4;
   localparam logic [3:0] ST_PT   = 4'd5;
   localparam logic [3:0] ST_DXGO = 4'd6;
   localparam logic [3:0] ST_DXW  = 4'd7;
   localparam logic [3:0] ST_DYGO = 4'd8;
   localparam logic [3:0] ST_DYW  = 4'd9;
   localparam logic [3:0] ST_EMIT = 4'd10;

   localparam logic [CL_BITS-1:0]   LAST_IDX   = CL_BITS'(CLUSTERS - 1);
   localparam logic [CL_BITS-1:0]   FIRST_CMP  = CL_BITS'(1);
   localparam logic [SLOT_BITS:0]   SLOT_LIMIT = (SLOT_BITS + 1)'(CLUSTERS);
   localparam count_type            PASS_LIMIT = CNT_BITS'(PASS_POINTS);

   localparam int X_LO = SLOT_BITS;
   localparam int Y_LO = SLOT_BITS + COORD_BITS;
   localparam int OX_LO = IDX_BITS;
   localparam int OY_LO = IDX_BITS + COORD_BITS;
   localparam int OV_AT = IDX_BITS + 2 * COORD_BITS;

   logic [3:0]            state_ff, state_in;
   coord_type             px_ff, px_in;
   coord_type             py_ff, py_in;
   logic                  end_ff, end_in;
   logic [CL_BITS-1:0]    i_ff, i_in;
   logic [CL_BITS-1:0]    best_ff, best_in;
   logic [DIST_BITS-1:0]  best_d_ff, best_d_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic [DIST_BITS-1:0]  dist_ff, dist_in;
   coord_type             qx_ff, qx_in;
   coord_type             qy_ff, qy_in;
   logic                  neg_ff, neg_in;
   coord_type             cent_x_ff [CLUSTERS];
   coord_type             cent_x_in [CLUSTERS];
   coord_type             cent_y_ff [CLUSTERS];
   coord_type             cent_y_in [CLUSTERS];
   sum_type               sum_x_ff [CLUSTERS];
   sum_type               sum_x_in [CLUSTERS];
   sum_type               sum_y_ff [CLUSTERS];
   sum_type               sum_y_in [CLUSTERS];
   count_type             cnt_ff [CLUSTERS];
   count_type             cnt_in [CLUSTERS];
   count_type             pass_cnt_ff, pass_cnt_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [SLOT_BITS-1:0]  req_slot;
   coord_type             req_x;
   coord_type             req_y;
   logic                  out_free;
   logic [CL_BITS-1:0]    rd_idx;
   sum_type               sum_x_rd;
   sum_type               sum_y_rd;
   count_type             cnt_rd;
   sum_type               px_ext;
   sum_type               py_ext;
   logic signed [COORD_BITS:0] diff;
   logic [COORD_BITS:0]   diff_abs;
   logic [COORD_BITS-1:0] mag;
   logic [SQ_BITS-1:0]    product;
   logic                  div_start;
   logic [SUM_BITS-1:0]   div_dividend;
   logic                  div_done;
   logic [SUM_BITS-1:0]   div_quo;
   logic [SUM_BITS-1:0]   quo_signed;

   assign req_slot = req_tdata[SLOT_BITS-1:0];
   assign req_x    = req_tdata[X_LO +: COORD_BITS];
   assign req_y    = req_tdata[Y_LO +: COORD_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // single read port on the accumulators: the winner while adding, else the sweep index
   assign rd_idx   = (state_ff == ST_ACC) ? best_ff : i_ff;
   assign sum_x_rd = sum_x_ff[rd_idx];
   assign sum_y_rd = sum_y_ff[rd_idx];
   assign cnt_rd   = cnt_ff[rd_idx];

   assign px_ext = {{CNT_BITS{px_ff[COORD_BITS-1]}}, px_ff};
   assign py_ext = {{CNT_BITS{py_ff[COORD_BITS-1]}}, py_ff};

   // shared squarer: |dx| in ST_SQX, |dy| otherwise; |diff| never exceeds 2^COORD_BITS-1
   always_comb begin
      if (state_ff == ST_SQX) begin
         diff = {px_ff[COORD_BITS-1], px_ff} - {cent_x_ff[i_ff][COORD_BITS-1], cent_x_ff[i_ff]};
      end else begin
         diff = {py_ff[COORD_BITS-1], py_ff} - {cent_y_ff[i_ff][COORD_BITS-1], cent_y_ff[i_ff]};
      end
      diff_abs = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
      mag      = diff_abs[COORD_BITS-1:0];
      product  = mag * mag;
   end

   assign quo_signed = neg_ff ? (~div_quo + 1'b1) : div_quo;

   kmp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_rd),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in    = state_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      end_in      = end_ff;
      i_in        = i_ff;
      best_in     = best_ff;
      best_d_in   = best_d_ff;
      sq_in       = sq_ff;
      dist_in     = dist_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      neg_in      = neg_ff;
      cent_x_in   = cent_x_ff;
      cent_y_in   = cent_y_ff;
      sum_x_in    = sum_x_ff;
      sum_y_in    = sum_y_ff;
      cnt_in      = cnt_ff;
      pass_cnt_in = pass_cnt_ff;
      ovf_in      = ovf_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_dividend = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               px_in  = req_x;
               py_in  = req_y;
               end_in = req_tlast;
               if (req_tuser == OP_LOAD) begin
                  // out-of-range slots are dropped
                  if ({1'b0, req_slot} < SLOT_LIMIT) begin
                     cent_x_in[req_slot[CL_BITS-1:0]] = req_x;
                     cent_y_in[req_slot[CL_BITS-1:0]] = req_y;
                  end
               end else begin
                  i_in     = '0;
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: begin
            sq_in = product;
            // judge the previous centroid's distance; first one always wins
            if (i_ff != '0) begin
               if (i_ff == FIRST_CMP || dist_ff < best_d_ff) begin
                  best_d_in = dist_ff;
                  best_in   = i_ff - 1'b1;
               end
            end
            state_in = ST_SQY;
         end
         ST_SQY: begin
            dist_in = {1'b0, sq_ff} + {1'b0, product};
            if (i_ff == LAST_IDX) begin
               state_in = ST_CMP;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SQX;
            end
         end
         ST_CMP: begin
            if (dist_ff < best_d_ff) begin
               best_d_in = dist_ff;
               best_in   = LAST_IDX;
            end
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (pass_cnt_ff >= PASS_LIMIT) begin
               ovf_in = 1'b1;
            end else begin
               sum_x_in[best_ff] = sum_x_rd + px_ext;
               sum_y_in[best_ff] = sum_y_rd + py_ext;
               cnt_in[best_ff]   = cnt_rd + 1'b1;
               pass_cnt_in       = pass_cnt_ff + 1'b1;
            end
            state_in = ST_PT;
         end
         ST_PT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = KIND_ASSIGN;
               rsp_last_in  = !end_ff;
               rsp_data_in  = '0;
               rsp_data_in[IDX_BITS-1:0] = IDX_BITS'(best_ff);
               rsp_data_in[OV_AT] = ovf_ff;
               if (end_ff) begin
                  i_in     = '0;
                  state_in = ST_DXGO;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DXGO: begin
            if (cnt_rd == '0) begin
               qx_in    = '0;
               state_in = ST_DYGO;
            end else begin
               div_start    = 1'b1;
               neg_in       = sum_x_rd[SUM_BITS-1];
               div_dividend = sum_x_rd[SUM_BITS-1] ? (~sum_x_rd + 1'b1) : sum_x_rd;
               state_in     = ST_DXW;
            end
         end
         ST_DXW: begin
            if (div_done) begin
               qx_in    = quo_signed[COORD_BITS-1:0];
               state_in = ST_DYGO;
            end
         end
         ST_DYGO: begin
            if (cnt_rd == '0) begin
               qy_in    = '0;
               state_in = ST_EMIT;
            end else begin
               div_start    = 1'b1;
               neg_in       = sum_y_rd[SUM_BITS-1];
               div_dividend = sum_y_rd[SUM_BITS-1] ? (~sum_y_rd + 1'b1) : sum_y_rd;
               state_in     = ST_DYW;
            end
         end
         ST_DYW: begin
            if (div_done) begin
               qy_in    = quo_signed[COORD_BITS-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = KIND_CENTROID;
               rsp_last_in  = (i_ff == LAST_IDX);
               rsp_data_in  = '0;
               rsp_data_in[IDX_BITS-1:0]        = IDX_BITS'(i_ff);
               rsp_data_in[OX_LO +: COORD_BITS] = qx_ff;
               rsp_data_in[OY_LO +: COORD_BITS] = qy_ff;
               rsp_data_in[OV_AT]               = ovf_ff;
               // new centroid in, this cluster's accumulators cleared
               cent_x_in[i_ff] = qx_ff;
               cent_y_in[i_ff] = qy_ff;
               sum_x_in[i_ff]  = '0;
               sum_y_in[i_ff]  = '0;
               cnt_in[i_ff]    = '0;
               if (i_ff == LAST_IDX) begin
                  pass_cnt_in = '0;
                  ovf_in      = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_DXGO;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < CLUSTERS; k++) begin
            cent_x_ff[k] <= '0;
            cent_y_ff[k] <= '0;
            sum_x_ff[k]  <= '0;
            sum_y_ff[k]  <= '0;
            cnt_ff[k]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pass_cnt_ff  <= pass_cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         cent_x_ff    <= cent_x_in;
         cent_y_ff    <= cent_y_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         cnt_ff       <= cnt_in;
      end
      px_ff       <= px_in;
      py_ff       <= py_in;
      end_ff      <= end_in;
      i_ff        <= i_in;
      best_ff     <= best_in;
      best_d_ff   <= best_d_in;
      sq_ff       <= sq_in;
      dist_ff     <= dist_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      neg_ff      <= neg_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/kmp_div.sv -----
module kmp_div import kmp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_BITS-1:0] dividend,
   input  count_type           divisor,
   output logic                done,
   output logic [SUM_BITS-1:0] quotient
);

   localparam int STEP_BITS = $clog2(SUM_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(SUM_BITS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   count_type            rem_ff, rem_in;
   count_type            dvs_ff, dvs_in;
   logic [SUM_BITS-1:0]  quo_ff, quo_in;
   logic [CNT_BITS:0]    trial;
   logic [CNT_BITS:0]    diff;

   // restoring division, one quotient bit per cycle, MSB first
   assign trial = {rem_ff, quo_ff[SUM_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!diff[CNT_BITS]) begin
            rem_in = diff[CNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- tb/kmeans_2d_pass_unit_tb.sv -----
`timescale 1ns / 1ps

module kmeans_2d_pass_unit_tb;
   import kmp_pkg::*;

   // run limit, far above the slowest legal run (about 170 beats, a pass end
   // every few beats, receiver stalls on every result)
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 400;   // longer than one pass-end sequence
   localparam int RAND_TOTAL = 170;
   localparam int DIR_ROWS = 22;

   // one input beat, plus an optional hand-typed assignment index
   typedef struct {
      logic      op;
      logic [3:0] slot;
      coord_type x;
      coord_type y;
      logic      last;
      bit        typed;
      logic [3:0] idx;
   } stim_row_type;

   // one expected result beat
   typedef struct {
      logic       kind;
      logic [3:0] idx;
      coord_type  x;
      coord_type  y;
      logic       ovf;
      logic       last;
   } rsp_beat_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // slot[3:0], x[19:4], y[35:20]
   logic                     req_tuser = 1'b0; // opcode
   logic                     req_tlast = 1'b0; // last_of_pass
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // index[3:0], x[19:4], y[35:20], ovf[36]
   logic                     rsp_tuser;        // result_kind
   logic                     rsp_tlast;        // last

   kmeans_2d_pass_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Clustering model: centroid table, per-cluster sums and member counts.
   // ------------------------------------------------------------------
   coord_type cent_x [CLUSTERS];
   coord_type cent_y [CLUSTERS];
   longint    acc_x [CLUSTERS];
   longint    acc_y [CLUSTERS];
   int        member_cnt [CLUSTERS];
   int        pass_pts = 0;
   bit        pass_ovf = 1'b0;

   stim_row_type stim_q [$];
   rsp_beat_type rsp_expect_q [$];

   int err_cnt = 0;
   int rsp_beats = 0;
   int items_done = 0;
   int items_total = 0;
   int cycle_cnt = 0;

   initial begin
      for (int i = 0; i < CLUSTERS; i++) begin
         cent_x[i] = '0;
         cent_y[i] = '0;
         acc_x[i] = 0;
         acc_y[i] = 0;
         member_cnt[i] = 0;
      end
   end

   // Apply one accepted beat to the model and queue the beats it causes.
   task automatic cluster_model_step(input stim_row_type it);
      longint       dx, dy, d, best_d;
      int           best;
      longint       nx, ny;
      rsp_beat_type b;
      best = 0;
      best_d = 0;
      if (it.op == OP_LOAD) begin
         // slots past the table are dropped; tlast means nothing on a load
         if (it.slot < CLUSTERS) begin
            cent_x[it.slot] = it.x;
            cent_y[it.slot] = it.y;
         end
      end else begin
         for (int i = 0; i < CLUSTERS; i++) begin
            dx = longint'(it.x) - longint'(cent_x[i]);
            dy = longint'(it.y) - longint'(cent_y[i]);
            d = dx * dx + dy * dy;
            // strict compare: lowest index keeps a tie
            if (i == 0 || d < best_d) begin
               best_d = d;
               best = i;
            end
         end
         // capacity: classify always, accumulate only below PASS_POINTS
         if (pass_pts >= PASS_POINTS) begin
            pass_ovf = 1'b1;
         end else begin
            acc_x[best] += longint'(it.x);
            acc_y[best] += longint'(it.y);
            member_cnt[best]++;
            pass_pts++;
         end
         b.kind = KIND_ASSIGN;
         b.idx  = it.typed ? it.idx : 4'(best);
         b.x    = '0;
         b.y    = '0;
         b.ovf  = pass_ovf;
         b.last = !it.last;
         rsp_expect_q.push_back(b);
         if (it.last) begin
            // pass end: mean per cluster, truncated toward zero; empty -> origin
            for (int i = 0; i < CLUSTERS; i++) begin
               nx = 0;
               ny = 0;
               if (member_cnt[i] > 0) begin
                  nx = acc_x[i] / longint'(member_cnt[i]);
                  ny = acc_y[i] / longint'(member_cnt[i]);
               end
               cent_x[i] = coord_type'(nx);
               cent_y[i] = coord_type'(ny);
               b.kind = KIND_CENTROID;
               b.idx  = 4'(i);
               b.x    = coord_type'(nx);
               b.y    = coord_type'(ny);
               b.ovf  = pass_ovf;
               b.last = (i == CLUSTERS - 1);
               rsp_expect_q.push_back(b);
            end
            for (int i = 0; i < CLUSTERS; i++) begin
               acc_x[i] = 0;
               acc_y[i] = 0;
               member_cnt[i] = 0;
            end
            pass_pts = 0;
            pass_ovf = 1'b0;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch rsp beat %0d %s: got %0d want %0d", rsp_beats, what, got, want);
      err_cnt++;
   endtask

   task automatic add_item(input logic op, input logic [3:0] slot, input coord_type x,
                           input coord_type y, input logic last);
      stim_row_type r;
      r.op = op;
      r.slot = slot;
      r.x = x;
      r.y = y;
      r.last = last;
      r.typed = 1'b0;
      r.idx = '0;
      stim_q.push_back(r);
   endtask

   // coordinate near a hub, full random, or a rail value
   function automatic coord_type pick_coord(input int hub);
      int r;
      r = $urandom_range(0, 9);
      if (r < 2)
         return coord_type'($urandom);
      else if (r == 2)
         return $urandom_range(0, 1) ? coord_type'(32767) : coord_type'(-32768);
      else
         return coord_type'(hub + int'($urandom_range(0, 1023)) - 512);
   endfunction

   // ------------------------------------------------------------------
   // Directed table. Typed index only where it is obvious; the pass-end
   // centroids and the untyped rows come from the model.
   // ------------------------------------------------------------------
   stim_row_type dir_tab [DIR_ROWS];

   initial begin
      int hub [CLUSTERS];
      int sel, n, h;
      dir_tab = '{
         // after reset every centroid is the origin: all tie, index 0 wins
         '{OP_POINT, 0,       0,      0, 0, 1, 0},
         '{OP_POINT, 7,   32767,  32767, 0, 1, 0},
         '{OP_POINT, 8,  -32768, -32768, 0, 1, 0},
         // slot past the table is ignored
         '{OP_LOAD, 15,    1000,   1000, 0, 0, 0},
         '{OP_POINT, 0,    1000,   1000, 0, 1, 0},
         '{OP_LOAD,  4,  -32768, -32768, 0, 0, 0},
         '{OP_LOAD,  3,   32767,  32767, 0, 0, 0},
         // out of range load with tlast set: still no result
         '{OP_LOAD,  5,       0,      0, 1, 0, 0},
         '{OP_POINT, 0,  -32768, -32768, 0, 1, 4},
         '{OP_POINT, 0,   32767,  32767, 0, 1, 3},
         '{OP_LOAD,  1,     256,      0, 0, 0, 0},
         '{OP_LOAD,  2,    -256,      0, 0, 0, 0},
         // pass end, clusters 1 and 2 empty -> origin
         '{OP_POINT, 0,       0,      0, 1, 1, 0},
         '{OP_LOAD,  0,     100,      0, 0, 0, 0},
         '{OP_LOAD,  1,    -100,      0, 0, 0, 0},
         '{OP_LOAD,  2,   32767,  32767, 0, 0, 0},
         '{OP_LOAD,  3,  -32768,  32767, 0, 0, 0},
         '{OP_LOAD,  4,   32767, -32768, 0, 0, 0},
         // equidistant from 0 and 1: lower index
         '{OP_POINT, 0,       0,      0, 0, 1, 0},
         '{OP_POINT, 0,       0,      5, 0, 1, 0},
         '{OP_POINT, 0,      -1,      0, 0, 1, 1},
         // negative odd sum in cluster 1: quotient truncates toward zero
         '{OP_POINT, 15, -32768, -32768, 1, 0, 0}
      };
      for (int i = 0; i < DIR_ROWS; i++)
         stim_q.push_back(dir_tab[i]);

      // Random part: mostly well-formed passes, some stray loads and
      // passes broken off without tlast. The capacity limit of PASS_POINTS
      // points is out of reach at this run length.
      while (stim_q.size() < RAND_TOTAL) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) begin
            for (int i = 0; i < CLUSTERS; i++)
               hub[i] = int'($urandom_range(0, 48000)) - 24000;
            if ($urandom_range(0, 1))
               for (int i = 0; i < CLUSTERS; i++)
                  add_item(OP_LOAD, 4'(i), pick_coord(hub[i]), pick_coord(hub[i]),
                           1'($urandom));
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) begin
               h = hub[$urandom_range(0, CLUSTERS - 1)];
               add_item(OP_POINT, 4'($urandom), pick_coord(h), pick_coord(h), k == n - 1);
            end
         end else if (sel < 8) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
               add_item(OP_LOAD, 4'($urandom_range(0, 15)), coord_type'($urandom),
                        coord_type'($urandom), 1'($urandom));
         end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
               add_item(OP_POINT, 4'($urandom), coord_type'($urandom),
                        coord_type'($urandom), 1'b0);
         end
      end
      items_total = stim_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (items_done < items_total) @(posedge clock);
      while (rsp_expect_q.size() != 0) @(posedge clock);
      // stray beats after the last expected one still get caught here
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Request side: bursts of random length with random gaps between them.
   // Only one NBA per signal per edge; a held beat is never dropped.
   // ------------------------------------------------------------------
   stim_row_type             cur_item;
   logic [REQ_DATA_BITS-1:0] drive_word;
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            cluster_model_step(cur_item);
            items_done++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (stim_q.size() > 0) begin
               cur_item = stim_q.pop_front();
               drive_word = '0;
               drive_word[3:0] = cur_item.slot;
               drive_word[19:4] = cur_item.x;
               drive_word[35:20] = cur_item.y;
               req_tvalid <= 1'b1;
               req_tdata <= drive_word;
               req_tuser <= cur_item.op;
               req_tlast <= cur_item.last;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  // about a quarter of the bursts run straight into the next
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side: the ready pattern switches among randomly chosen modes
   // (always ready, coin flip, mostly stalled, rotating mask).
   // ------------------------------------------------------------------
   rsp_beat_type want_beat;
   logic [15:0]  stall_mask = 16'hffff;
   int           stall_mode = 0;
   int           stall_cyc = 0;
   logic         rdy;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_expect_q.size() == 0) begin
               report_mismatch("unexpected beat, kind", rsp_tuser, -1);
            end else begin
               want_beat = rsp_expect_q.pop_front();
               if (rsp_tuser !== want_beat.kind)
                  report_mismatch("kind", rsp_tuser, want_beat.kind);
               if (rsp_tdata[3:0] !== want_beat.idx)
                  report_mismatch("index", rsp_tdata[3:0], want_beat.idx);
               if (rsp_tdata[19:4] !== want_beat.x)
                  report_mismatch("x", longint'($signed(rsp_tdata[19:4])), want_beat.x);
               if (rsp_tdata[35:20] !== want_beat.y)
                  report_mismatch("y", longint'($signed(rsp_tdata[35:20])), want_beat.y);
               if (rsp_tdata[36] !== want_beat.ovf)
                  report_mismatch("overflow", rsp_tdata[36], want_beat.ovf);
               if (rsp_tlast !== want_beat.last)
                  report_mismatch("last", rsp_tlast, want_beat.last);
            end
            rsp_beats++;
         end
         stall_cyc++;
         if (stall_cyc % 48 == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mask = 16'($urandom);
         end
         case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = stall_mask[stall_cyc % 16];
         endcase
         rsp_tready <= rdy;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
